@@ rtl/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 step for the measurement frame decoder.
// No dependencies; every other file in rtl/ imports this package.

package htfd_pkg;

    // Frame layout: six data bytes, then one check byte
    localparam logic [2:0] FRAME_LEN = 3'd7;
    localparam logic [2:0] DATA_LEN  = 3'd6;

    // CRC-8: polynomial x^8+x^5+x^4+1, MSB first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scaling: humidity 0.01 %, temperature 0.01 degC with a -50 degC offset
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC_ERR  = 3'd1;
    localparam logic [2:0] ST_NO_BYTES = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_ALL_ZERO = 3'd4;

    // Finished frame handed from the accumulator to the decoder
    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] frame;
    } frame_snap_t;

    // One byte through the CRC, eight shift steps
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
            else      c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/htfd_accum.sv @@
// Byte accumulator: frame bytes, running CRC, zero flag and byte count.
// On the end of a read it registers a finished frame snapshot. Uses htfd_pkg.

module htfd_accum import htfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        byte_present,
    input  logic        end_of_read,
    input  logic        advance,
    output logic        snap_valid,
    output frame_snap_t snap
);

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic        zero_reg, zero_next;
    logic [47:0] frame_reg, frame_next;
    logic [7:0]  chk_reg, chk_next;
    logic        snap_valid_reg, snap_valid_next;
    frame_snap_t snap_reg, snap_next;
    logic        in_fire;

    // Accept while the snapshot slot is free or drains this cycle
    assign in_ready = !snap_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Merge the incoming byte into the frame state
    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        zero_next  = zero_reg;
        frame_next = frame_reg;
        chk_next   = chk_reg;
        if (byte_present && count_reg != FRAME_LEN)
        begin
            if (count_reg < DATA_LEN)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    if (count_reg == 3'(i)) frame_next[47 - 8*i -: 8] = rx_byte;
                end
                crc_next = crc8_update(crc_reg, rx_byte);
            end
            else
            begin
                chk_next = rx_byte;
            end
            if (rx_byte != 8'd0) zero_next = 1'b0;
            count_next = count_reg + 3'd1;
        end
    end

    // Classify the frame as it stands after this byte
    always_comb
    begin
        snap_next.frame = frame_next;
        priority if (count_next == 3'd0)       snap_next.status = ST_NO_BYTES;
        else if (count_next != FRAME_LEN)      snap_next.status = ST_MISSING;
        else if (zero_next)                    snap_next.status = ST_ALL_ZERO;
        else if (crc_next == chk_next)         snap_next.status = ST_OK;
        else                                   snap_next.status = ST_CRC_ERR;
    end

    // Hold the snapshot until the decoder takes it
    always_comb
    begin
        if (in_fire && end_of_read) snap_valid_next = 1'b1;
        else if (advance)           snap_valid_next = 1'b0;
        else                        snap_valid_next = snap_valid_reg;
    end

    // Frame state: advance on each item, clear at the end of a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= 3'd0;
            crc_reg        <= CRC_INIT;
            zero_reg       <= 1'b1;
            frame_reg      <= 48'd0;
            chk_reg        <= 8'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (in_fire)
            begin
                if (end_of_read)
                begin
                    count_reg <= 3'd0;
                    crc_reg   <= CRC_INIT;
                    zero_reg  <= 1'b1;
                    frame_reg <= 48'd0;
                    chk_reg   <= 8'd0;
                end
                else
                begin
                    count_reg <= count_next;
                    crc_reg   <= crc_next;
                    zero_reg  <= zero_next;
                    frame_reg <= frame_next;
                    chk_reg   <= chk_next;
                end
            end
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        if (in_fire && end_of_read) snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

`ifndef SYNTH
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_read) |=> (count_reg == 3'd0 && crc_reg == CRC_INIT && zero_reg))
        else $error("frame state not cleared after end of read");
    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !advance) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("pending snapshot lost or changed");
    a_snap_status: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg |-> (snap_reg.status <= ST_ALL_ZERO))
        else $error("snapshot holds an unknown status code");
`endif

endmodule

@@ rtl/htfd_decode.sv @@
// Frame decoder and result register: unpacks status and raw values, scales them.
// Fed by htfd_accum through a frame_snap_t; uses htfd_pkg.

module htfd_decode import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  frame_snap_t        snap,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         frame_status,
    output logic [7:0]         sensor_state_byte,
    output logic [19:0]        humidity_raw,
    output logic [19:0]        temperature_raw,
    output logic [13:0]        humidity_centi,
    output logic signed [14:0] temperature_centi
);

    logic        decoded;
    logic [19:0] hraw, traw;
    logic [33:0] hum_prod;
    logic [34:0] temp_prod;
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  state_reg;
    logic [19:0] hraw_reg, traw_reg;
    logic [13:0] hc_reg;
    logic [14:0] tc_reg;

    // Result register is free or being emptied
    assign advance = !out_valid_reg || out_ready;

    // Unpack the frame; non-decoded statuses give zero fields
    assign decoded = (snap.status == ST_OK) || (snap.status == ST_CRC_ERR);
    assign hraw    = {snap.frame[39:32], snap.frame[31:24], snap.frame[23:20]};
    assign traw    = {snap.frame[19:16], snap.frame[15:8], snap.frame[7:0]};

    // Scale by constants, keep the integer part
    assign hum_prod  = 34'(hraw) * 34'(HUM_SCALE);
    assign temp_prod = 35'(traw) * 35'(TEMP_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (advance) out_valid_reg <= snap_valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && snap_valid)
        begin
            status_reg <= snap.status;
            if (decoded)
            begin
                state_reg <= snap.frame[47:40];
                hraw_reg  <= hraw;
                traw_reg  <= traw;
                hc_reg    <= hum_prod[33:20];
                tc_reg    <= temp_prod[34:20] - TEMP_OFFSET;
            end
            else
            begin
                state_reg <= 8'd0;
                hraw_reg  <= 20'd0;
                traw_reg  <= 20'd0;
                hc_reg    <= 14'd0;
                tc_reg    <= 15'd0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_status      = status_reg;
    assign sensor_state_byte = state_reg;
    assign humidity_raw      = hraw_reg;
    assign temperature_raw   = traw_reg;
    assign humidity_centi    = hc_reg;
    assign temperature_centi = signed'(tc_reg);

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK && status_reg != ST_CRC_ERR)
            |-> (hraw_reg == 20'd0 && traw_reg == 20'd0 && tc_reg == 15'd0))
        else $error("undecoded frame carries nonzero fields");
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hc_reg < HUM_SCALE))
        else $error("humidity out of range");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && snap_valid) |=> out_valid_reg)
        else $error("snapshot taken but no result shown");
`endif

endmodule

@@ rtl/humidity_temp_frame_decoder_crc8.sv @@
// Top level of the humidity/temperature frame decoder with CRC-8 check.
// Instantiates htfd_accum and htfd_decode; uses htfd_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | rx_byte, byte_present, end_of_read
//   out     | out_valid / out_ready| frame_status, sensor_state_byte, humidity_raw,
//           |                      | temperature_raw, humidity_centi, temperature_centi
//
// One item per cycle is taken while in_ready is high; the frame closed by an item
// ending a read is held in the accumulator snapshot register, then the result register.
// The snapshot and result registers form a two-deep pipe, so input stalls only
// when both hold results and out_ready is low.
// rst_n clears the frame state (count 0, CRC 0xFF, zero flag set) and both valids.

module humidity_temp_frame_decoder_crc8 import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               byte_present,
    input  logic               end_of_read,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         frame_status,
    output logic [7:0]         sensor_state_byte,
    output logic [19:0]        humidity_raw,
    output logic [19:0]        temperature_raw,
    output logic [13:0]        humidity_centi,
    output logic signed [14:0] temperature_centi
);

    logic        advance;
    logic        snap_valid;
    frame_snap_t snap;

    // Gather bytes and close frames
    htfd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .byte_present (byte_present),
        .end_of_read  (end_of_read),
        .advance      (advance),
        .snap_valid   (snap_valid),
        .snap         (snap)
    );

    // Decode and hold results
    htfd_decode u_decode (
        .clk               (clk),
        .rst_n             (rst_n),
        .snap_valid        (snap_valid),
        .snap              (snap),
        .advance           (advance),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .frame_status      (frame_status),
        .sensor_state_byte (sensor_state_byte),
        .humidity_raw      (humidity_raw),
        .temperature_raw   (temperature_raw),
        .humidity_centi    (humidity_centi),
        .temperature_centi (temperature_centi)
    );

endmodule
